// ----- design/series_function_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Series function unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, idle during reset.
// ----------------------------------------------------------------------------
`ifndef SERIES_FUNCTION_UNIT_MACROS_SVH
`define SERIES_FUNCTION_UNIT_MACROS_SVH

// same-cycle implication
`define SFU_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sfu_pkg.sv -----
// ----------------------------------------------------------------------------
// Series function unit package
// Field widths, function and status codes, datapath command and status types.
// ----------------------------------------------------------------------------
package sfu_pkg;

	localparam int CMD_W      = 3;
	localparam int OPND_W     = 32;
	localparam int VAL_W      = 40;
	localparam int STAT_W     = 2;
	localparam int USED_W     = 5;
	localparam int MAXT_W     = 4;
	localparam int THR_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	// internal values: signed, magnitude held to 2^55 - 1
	localparam int INT_W  = 56;
	localparam int MAG_W  = 55;
	localparam int PART_W = 28;
	localparam int K_W    = 11;
	localparam int IDX_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		FN_EXP   = 3'd0,
		FN_SIN   = 3'd1,
		FN_COS   = 3'd2,
		FN_LOG1P = 3'd3,
		FN_SQRT  = 3'd4
	} fn_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_SAT    = 2'd1,
		ST_DOMAIN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_MUL,
		OP_DIV,
		OP_ADD,
		OP_MOVE,
		OP_FINAL
	} dp_op_t;

	typedef enum logic [3:0] {
		SRC_X,
		SRC_TERM,
		SRC_AUX,
		SRC_COEF,
		SRC_SUM,
		SRC_MRES,
		SRC_DRES,
		SRC_BIN,
		SRC_NUM
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_TERM,
		DST_AUX,
		DST_COEF,
		DST_SUM
	} dst_t;

	typedef struct packed {
		dp_op_t            op;
		src_t              src_a;
		src_t              src_b;
		dst_t              dst;
		logic              neg;
		logic              shift;
		logic              den_x;
		logic [K_W-1:0]    k;
		logic [IDX_W-1:0]  idx;
		logic              domain;
		logic [USED_W-1:0] used;
	} dp_cmd_t;

	typedef struct packed {
		logic unit_done;
		logic term_big;
		logic coef_big;
		logic x_pos;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- design/sfu_if.sv -----
// ----------------------------------------------------------------------------
// Series function unit channels
// Request (command, operand) and response (value, status, terms) channels.
// ----------------------------------------------------------------------------
interface sfu_req_if;
	import sfu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [OPND_W-1:0] operand;

	modport source (output valid, output command, output operand, input ready);
	modport sink (input valid, input command, input operand, output ready);
endinterface

interface sfu_rsp_if;
	import sfu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic [STAT_W-1:0]       status;
	logic [USED_W-1:0]       terms_used;

	modport source (output valid, output value, output status, output terms_used,
		input ready);
	modport sink (input valid, input value, input status, input terms_used,
		output ready);
endinterface

// ----- design/sfu_mul.sv -----
// ----------------------------------------------------------------------------
// Series function unit: fixed-point multiplier
// Sign-magnitude (a*b) >> FRAC_BITS over four 28x28 partial products,
// truncated toward zero and saturated to the internal range.
// ----------------------------------------------------------------------------
module sfu_mul #(
	parameter int FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [sfu_pkg::INT_W-1:0] a,
	input  logic signed [sfu_pkg::INT_W-1:0] b,
	output logic                       busy,
	output logic                       done,
	output logic signed [sfu_pkg::INT_W-1:0] res,
	output logic                       sat
);
	import sfu_pkg::*;

	localparam int ACC_W = 4 * PART_W - 2;

	logic [2:0]              step_q;
	logic                    busy_q;
	logic                    done_q;
	logic [MAG_W-1:0]        ma_q;
	logic [MAG_W-1:0]        mb_q;
	logic                    neg_q;
	logic [2*PART_W-1:0]     prod_q;
	logic [1:0]              sh_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [INT_W-1:0] res_q;
	logic                    sat_q;

	logic [INT_W-1:0]  abs_a;
	logic [INT_W-1:0]  abs_b;
	logic [PART_W-1:0] a_part;
	logic [PART_W-1:0] b_part;
	logic [ACC_W-1:0]  addend;
	logic [ACC_W-1:0]  shifted;
	logic              ovf;
	logic [MAG_W-1:0]  mag;

	always_comb begin
		abs_a  = a[INT_W-1] ? INT_W'(-a) : INT_W'(a);
		abs_b  = b[INT_W-1] ? INT_W'(-b) : INT_W'(b);
		a_part = step_q[0] ? PART_W'(ma_q[MAG_W-1:PART_W]) : ma_q[PART_W-1:0];
		b_part = step_q[1] ? PART_W'(mb_q[MAG_W-1:PART_W]) : mb_q[PART_W-1:0];
		case (sh_q)
			2'd0: begin
				addend = ACC_W'(prod_q);
			end
			2'd1: begin
				addend = ACC_W'(prod_q) << PART_W;
			end
			default: begin
				addend = ACC_W'(prod_q) << (2 * PART_W);
			end
		endcase
		shifted = acc_q >> FRAC_BITS;
		ovf     = |shifted[ACC_W-1:MAG_W];
		mag     = ovf ? {MAG_W{1'b1}} : shifted[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= abs_a[MAG_W-1:0];
			mb_q  <= abs_b[MAG_W-1:0];
			neg_q <= a[INT_W-1] ^ b[INT_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				prod_q <= a_part * b_part;
				sh_q   <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			end
			if (step_q != 3'd0 && step_q < 3'd5) begin
				acc_q <= acc_q + addend;
			end
			if (step_q == 3'd5) begin
				res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				sat_q <= ovf;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;
endmodule

// ----- design/sfu_div.sv -----
// ----------------------------------------------------------------------------
// Series function unit: restoring divider
// Unsigned magnitude over a 32-bit divisor, one quotient bit per cycle,
// sign of the dividend reapplied, quotient saturated to the internal range.
// ----------------------------------------------------------------------------
module sfu_div #(
	parameter int FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [((32 + FRAC_BITS > 56) ? 32 + FRAC_BITS : 56)-1:0] dividend,
	input  logic                       neg,
	input  logic [31:0]                divisor,
	output logic                       busy,
	output logic                       done,
	output logic signed [sfu_pkg::INT_W-1:0] res,
	output logic                       sat
);
	import sfu_pkg::*;

	localparam int DW    = (32 + FRAC_BITS > 56) ? 32 + FRAC_BITS : 56;
	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DW-1:0]           quo_q;
	logic [31:0]             rem_q;
	logic [31:0]             den_q;
	logic                    neg_q;
	logic signed [INT_W-1:0] res_q;
	logic                    sat_q;

	logic [32:0]      trial;
	logic             fits;
	logic             ovf;
	logic [MAG_W-1:0] mag;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, den_q};
		ovf   = |quo_q[DW-1:MAG_W];
		mag   = ovf ? {MAG_W{1'b1}} : quo_q[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
				quo_q <= {quo_q[DW-2:0], fits};
			end else begin
				res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				sat_q <= ovf;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;
	assign sat  = sat_q;
endmodule

// ----- design/sfu_dpath.sv -----
// ----------------------------------------------------------------------------
// Series function unit: datapath
// Working registers, saturating accumulator, shared multiplier and divider,
// and the result register toward the response channel.
// ----------------------------------------------------------------------------
module sfu_dpath #(
	parameter int FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfu_pkg::dp_cmd_t                  cmd,
	output sfu_pkg::dp_stat_t                 stat,
	input  logic [sfu_pkg::CMD_W-1:0]         req_command,
	input  logic signed [sfu_pkg::OPND_W-1:0] req_operand,
	input  logic [sfu_pkg::THR_W-1:0]         threshold,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic signed [sfu_pkg::VAL_W-1:0]  rsp_value,
	output logic [sfu_pkg::STAT_W-1:0]        rsp_status,
	output logic [sfu_pkg::USED_W-1:0]        rsp_terms_used
);
	import sfu_pkg::*;

	localparam int DW = (32 + FRAC_BITS > 56) ? 32 + FRAC_BITS : 56;
	localparam logic signed [INT_W-1:0] ONE_V  = INT_W'(1) << FRAC_BITS;
	localparam logic signed [INT_W-1:0] HALF_V = INT_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [INT_W:0]   POS_LIM = {2'b00, {MAG_W{1'b1}}};
	localparam logic signed [INT_W-1:0] OUT_HI  = {{(INT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] OUT_LO  = {{(INT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

	logic signed [INT_W-1:0] x_q;
	logic signed [INT_W-1:0] term_q;
	logic signed [INT_W-1:0] aux_q;
	logic signed [INT_W-1:0] coef_q;
	logic signed [INT_W-1:0] sum_q;
	logic                    sat_q;
	dst_t                    pend_dst_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [USED_W-1:0]       out_used_q;

	logic signed [INT_W-1:0] val_a;
	logic signed [INT_W-1:0] val_b;
	logic signed [INT_W-1:0] num_v;
	logic signed [INT_W-1:0] bin_v;
	logic signed [INT_W-1:0] idx_m1;
	logic [INT_W-1:0]        abs_a;
	logic [DW-1:0]           dvd;
	logic [31:0]             den;
	logic signed [INT_W:0]   add_full;
	logic signed [INT_W-1:0] add_res;
	logic                    add_clip;
	logic                    wr_en;
	dst_t                    wr_dst;
	logic signed [INT_W-1:0] wr_val;
	logic                    sat_set;
	logic                    out_clip;
	logic signed [VAL_W-1:0] out_val;
	logic [INT_W-1:0]        term_abs;
	logic [INT_W-1:0]        coef_abs;

	logic                    mul_busy;
	logic                    mul_done;
	logic signed [INT_W-1:0] mul_res;
	logic                    mul_sat;
	logic                    div_busy;
	logic                    div_done;
	logic signed [INT_W-1:0] div_res;
	logic                    div_sat;

	function automatic logic signed [INT_W-1:0] pick(input src_t s);
		case (s)
			SRC_X:    return x_q;
			SRC_TERM: return term_q;
			SRC_AUX:  return aux_q;
			SRC_COEF: return coef_q;
			SRC_SUM:  return sum_q;
			SRC_MRES: return mul_res;
			SRC_DRES: return div_res;
			SRC_BIN:  return bin_v;
			SRC_NUM:  return num_v;
			default:  return x_q;
		endcase
	endfunction

	always_comb begin
		num_v  = ONE_V - x_q;
		idx_m1 = $signed(INT_W'(cmd.idx)) - $signed(INT_W'(1));
		bin_v  = HALF_V - (idx_m1 <<< FRAC_BITS);
		val_a  = pick(cmd.src_a);
		val_b  = pick(cmd.src_b);
		abs_a  = val_a[INT_W-1] ? INT_W'(-val_a) : INT_W'(val_a);
		dvd    = cmd.shift ? (DW'(abs_a[MAG_W-1:0]) << FRAC_BITS) : DW'(abs_a[MAG_W-1:0]);
		den    = cmd.den_x ? x_q[31:0] : 32'(cmd.k);

		// saturating accumulate into the running sum
		add_full = {sum_q[INT_W-1], sum_q} +
			(cmd.neg ? -{val_a[INT_W-1], val_a} : {val_a[INT_W-1], val_a});
		add_clip = (add_full > POS_LIM) || (add_full < -POS_LIM);
		if (add_full > POS_LIM) begin
			add_res = INT_W'(POS_LIM);
		end else if (add_full < -POS_LIM) begin
			add_res = INT_W'(-POS_LIM);
		end else begin
			add_res = add_full[INT_W-1:0];
		end

		wr_en   = 1'b1;
		wr_dst  = DST_NONE;
		wr_val  = val_a;
		sat_set = 1'b0;
		if (mul_done) begin
			wr_dst  = pend_dst_q;
			wr_val  = mul_res;
			sat_set = mul_sat;
		end else if (div_done) begin
			wr_dst  = pend_dst_q;
			wr_val  = div_res;
			sat_set = div_sat;
		end else if (cmd.op == OP_MOVE) begin
			wr_dst = cmd.dst;
		end else if (cmd.op == OP_ADD) begin
			wr_dst  = DST_SUM;
			wr_val  = add_res;
			sat_set = add_clip;
		end else begin
			wr_en = 1'b0;
		end

		out_clip = (sum_q > OUT_HI) || (sum_q < OUT_LO);
		if (sum_q > OUT_HI) begin
			out_val = OUT_HI[VAL_W-1:0];
		end else if (sum_q < OUT_LO) begin
			out_val = OUT_LO[VAL_W-1:0];
		end else begin
			out_val = sum_q[VAL_W-1:0];
		end

		term_abs = term_q[INT_W-1] ? INT_W'(-term_q) : INT_W'(term_q);
		coef_abs = coef_q[INT_W-1] ? INT_W'(-coef_q) : INT_W'(coef_q);
	end

	sfu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_MUL),
		.a      (val_a),
		.b      (val_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	sfu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV),
		.dividend (dvd),
		.neg      (val_a[INT_W-1]),
		.divisor  (den),
		.busy     (div_busy),
		.done     (div_done),
		.res      (div_res),
		.sat      (div_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_FINAL) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_INIT) begin
			x_q    <= INT_W'(req_operand);
			coef_q <= ONE_V;
			sat_q  <= 1'b0;
			sum_q  <= (fn_t'(req_command) == FN_SQRT) ? ONE_V : '0;
			term_q <= (fn_t'(req_command) == FN_SIN || fn_t'(req_command) == FN_LOG1P)
				? INT_W'(req_operand) : ONE_V;
		end else begin
			if (sat_set) begin
				sat_q <= 1'b1;
			end
			if (wr_en) begin
				case (wr_dst)
					DST_TERM: term_q <= wr_val;
					DST_AUX:  aux_q  <= wr_val;
					DST_COEF: coef_q <= wr_val;
					DST_SUM:  sum_q  <= wr_val;
					default: begin
					end
				endcase
			end
		end
		if (cmd.op == OP_MUL || cmd.op == OP_DIV) begin
			pend_dst_q <= cmd.dst;
		end
		if (cmd.op == OP_FINAL) begin
			if (cmd.domain) begin
				out_value_q  <= '0;
				out_status_q <= ST_DOMAIN;
				out_used_q   <= '0;
			end else begin
				out_value_q  <= out_val;
				out_status_q <= (sat_q || out_clip) ? ST_SAT : ST_OK;
				out_used_q   <= cmd.used;
			end
		end
	end

	assign stat.unit_done = mul_done | div_done;
	assign stat.term_big  = term_abs > INT_W'(threshold);
	assign stat.coef_big  = coef_abs > INT_W'(threshold);
	assign stat.x_pos     = !x_q[INT_W-1] && (x_q != '0);
	assign stat.out_busy  = out_valid_q && !rsp_ready;

	assign rsp_valid      = out_valid_q;
	assign rsp_value      = out_value_q;
	assign rsp_status     = out_status_q;
	assign rsp_terms_used = out_used_q;

	`include "series_function_unit_macros.svh"

	`SFU_ASSERT_IMPL(a_one_unit, 1'b1, !(mul_busy && div_busy), "multiplier and divider both busy")
	`SFU_ASSERT_IMPL(a_final_slot, cmd.op == OP_FINAL, !out_valid_q || rsp_ready, "result overrun")
	`SFU_ASSERT_NEXT(a_final_shown, cmd.op == OP_FINAL, out_valid_q, "result not presented")
endmodule

// ----- design/sfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// Series function unit: controller
// Sequences each series term through the datapath: threshold check, add,
// multiply and divide, then the final scaling (sqrt only) and result write.
// ----------------------------------------------------------------------------
module sfu_ctrl #(
	parameter int TERM_LIMIT = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [sfu_pkg::CMD_W-1:0]   req_command,
	input  logic [sfu_pkg::MAXT_W-1:0]  max_terms,
	output sfu_pkg::dp_cmd_t            cmd,
	input  sfu_pkg::dp_stat_t           stat
);
	import sfu_pkg::*;

	localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAXT_W'('1)) + USED_W'(1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_X2,
		S_Q_UDIV,
		S_Q_MV,
		S_CHECK,
		S_T_ADD,
		S_T_MUL,
		S_T_DIV,
		S_L_DIV,
		S_L_ADD,
		S_L_MUL,
		S_Q_CMUL,
		S_Q_CDIV,
		S_Q_PMUL,
		S_Q_ADD,
		S_Q_PMUL2,
		S_Q_FMUL,
		S_FINAL,
		S_WAIT
	} state_t;

	state_t            state_q;
	state_t            ret_q;
	fn_t               fn_q;
	logic [IDX_W-1:0]  i_q;
	logic [USED_W-1:0] used_q;
	logic [IDX_W-1:0]  n_q;
	logic              domain_q;

	logic [IDX_W-1:0]  n_lim;
	logic [5:0]        tk;
	logic [11:0]       kprod;
	logic [K_W-1:0]    k_term;
	logic              go_on;
	fn_t               req_fn;

	always_comb begin
		req_fn = fn_t'(req_command);
		n_lim  = (32'(max_terms) > TERM_LIMIT) ? IDX_W'(TERM_LIMIT) : IDX_W'(max_terms);
		tk     = {i_q, 1'b0} + ((fn_q == FN_SIN) ? 6'd2 : 6'd1);
		kprod  = 12'(tk) * 12'(tk + 6'd1);
		k_term = (fn_q == FN_EXP) ? K_W'(i_q + IDX_W'(1)) : kprod[K_W-1:0];
		go_on  = (i_q <= n_q) && ((fn_q == FN_SQRT) ? stat.coef_big : stat.term_big);
	end

	always_comb begin
		cmd        = '0;
		cmd.op     = OP_NONE;
		cmd.src_a  = SRC_X;
		cmd.src_b  = SRC_X;
		cmd.dst    = DST_NONE;
		cmd.idx    = i_q;
		cmd.used   = used_q;
		cmd.domain = domain_q;
		req_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op = OP_INIT;
				end
			end
			S_X2: begin
				cmd.op  = OP_MUL;
				cmd.dst = DST_AUX;
			end
			S_Q_UDIV: begin
				cmd.op    = OP_DIV;
				cmd.src_a = SRC_NUM;
				cmd.shift = 1'b1;
				cmd.den_x = 1'b1;
				cmd.dst   = DST_AUX;
			end
			S_Q_MV: begin
				cmd.op    = OP_MOVE;
				cmd.src_a = SRC_AUX;
				cmd.dst   = DST_TERM;
			end
			S_T_ADD: begin
				cmd.op    = OP_ADD;
				cmd.src_a = SRC_TERM;
				cmd.neg   = (fn_q != FN_EXP) && i_q[0];
			end
			S_T_MUL: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_TERM;
				cmd.src_b = (fn_q == FN_EXP) ? SRC_X : SRC_AUX;
			end
			S_T_DIV: begin
				cmd.op    = OP_DIV;
				cmd.src_a = SRC_MRES;
				cmd.k     = k_term;
				cmd.dst   = DST_TERM;
			end
			S_L_DIV: begin
				cmd.op    = OP_DIV;
				cmd.src_a = SRC_TERM;
				cmd.k     = K_W'(i_q);
			end
			S_L_ADD: begin
				cmd.op    = OP_ADD;
				cmd.src_a = SRC_DRES;
				cmd.neg   = !i_q[0];
			end
			S_L_MUL: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_TERM;
				cmd.dst   = DST_TERM;
			end
			S_Q_CMUL: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_COEF;
				cmd.src_b = SRC_BIN;
			end
			S_Q_CDIV: begin
				cmd.op    = OP_DIV;
				cmd.src_a = SRC_MRES;
				cmd.k     = K_W'(i_q);
				cmd.dst   = DST_COEF;
			end
			S_Q_PMUL: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_COEF;
				cmd.src_b = SRC_TERM;
			end
			S_Q_ADD: begin
				cmd.op    = OP_ADD;
				cmd.src_a = SRC_MRES;
			end
			S_Q_PMUL2: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_TERM;
				cmd.src_b = SRC_AUX;
				cmd.dst   = DST_TERM;
			end
			S_Q_FMUL: begin
				cmd.op    = OP_MUL;
				cmd.src_a = SRC_SUM;
				cmd.dst   = DST_SUM;
			end
			S_FINAL: begin
				if (!stat.out_busy) begin
					cmd.op = OP_FINAL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			fn_q     <= FN_EXP;
			i_q      <= '0;
			used_q   <= '0;
			n_q      <= '0;
			domain_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						fn_q     <= req_fn;
						n_q      <= n_lim;
						domain_q <= 1'b0;
						i_q      <= (req_fn == FN_LOG1P || req_fn == FN_SQRT)
							? IDX_W'(1) : '0;
						used_q   <= (req_fn == FN_SQRT) ? USED_W'(1) : '0;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (fn_q)
						FN_EXP, FN_LOG1P: begin
							state_q <= S_CHECK;
						end
						FN_SIN, FN_COS: begin
							state_q <= S_X2;
						end
						FN_SQRT: begin
							if (stat.x_pos) begin
								state_q <= S_Q_UDIV;
							end else begin
								domain_q <= 1'b1;
								state_q  <= S_FINAL;
							end
						end
						default: begin
							domain_q <= 1'b1;
							state_q  <= S_FINAL;
						end
					endcase
				end
				S_X2: begin
					ret_q   <= S_CHECK;
					state_q <= S_WAIT;
				end
				S_Q_UDIV: begin
					ret_q   <= S_Q_MV;
					state_q <= S_WAIT;
				end
				S_Q_MV: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (go_on) begin
						case (fn_q)
							FN_LOG1P: state_q <= S_L_DIV;
							FN_SQRT:  state_q <= S_Q_CMUL;
							default:  state_q <= S_T_ADD;
						endcase
					end else begin
						state_q <= (fn_q == FN_SQRT) ? S_Q_FMUL : S_FINAL;
					end
				end
				S_T_ADD: begin
					state_q <= S_T_MUL;
				end
				S_T_MUL: begin
					ret_q   <= S_T_DIV;
					state_q <= S_WAIT;
				end
				S_T_DIV: begin
					i_q     <= i_q + IDX_W'(1);
					used_q  <= used_q + USED_W'(1);
					ret_q   <= S_CHECK;
					state_q <= S_WAIT;
				end
				S_L_DIV: begin
					ret_q   <= S_L_ADD;
					state_q <= S_WAIT;
				end
				S_L_ADD: begin
					state_q <= S_L_MUL;
				end
				S_L_MUL: begin
					i_q     <= i_q + IDX_W'(1);
					used_q  <= used_q + USED_W'(1);
					ret_q   <= S_CHECK;
					state_q <= S_WAIT;
				end
				S_Q_CMUL: begin
					ret_q   <= S_Q_CDIV;
					state_q <= S_WAIT;
				end
				S_Q_CDIV: begin
					ret_q   <= S_Q_PMUL;
					state_q <= S_WAIT;
				end
				S_Q_PMUL: begin
					ret_q   <= S_Q_ADD;
					state_q <= S_WAIT;
				end
				S_Q_ADD: begin
					state_q <= S_Q_PMUL2;
				end
				S_Q_PMUL2: begin
					i_q     <= i_q + IDX_W'(1);
					used_q  <= used_q + USED_W'(1);
					ret_q   <= S_CHECK;
					state_q <= S_WAIT;
				end
				S_Q_FMUL: begin
					ret_q   <= S_FINAL;
					state_q <= S_WAIT;
				end
				S_FINAL: begin
					// hold until the result register is free
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (stat.unit_done) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "series_function_unit_macros.svh"

	`SFU_ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready, state_q == S_DISPATCH, "accept lost")
	`SFU_ASSERT_IMPL(a_used_bound, state_q == S_CHECK, used_q <= USED_MAX, "term count overflow")
	`SFU_ASSERT_NEXT(a_issue_waits, cmd.op == OP_MUL || cmd.op == OP_DIV, state_q == S_WAIT, "unit not awaited")
endmodule

// ----- design/series_function_unit.sv -----
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  req     | sink   | command (3b), operand (signed Q8.F, 32b)
//  rsp     | source | value (signed Q16.F, 40b), status (2b), terms_used (5b)
//  cfg     | write  | cfg_we, cfg_index (0 max_terms, 1 term_threshold), cfg_data
//
//  One item at a time. Each term runs its multiplies and divides in turn, its
//  cost set mostly by the bit-serial divider over a DW-bit dividend,
//  DW = max(56, 32 + FRAC_BITS).
//  The result register frees the request side while a response stalls.
//  Reset: async, active low; config returns to max_terms 10, threshold 17.
// ----------------------------------------------------------------------------
// Series function unit
// Power series evaluator for exp, sin, cos, log1p and sqrt on fixed point.
// ----------------------------------------------------------------------------
module series_function_unit #(
	parameter int FRAC_BITS  = 24,
	parameter int TERM_LIMIT = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sfu_req_if.sink                              req,
	sfu_rsp_if.source                            rsp,
	input  logic                                 cfg_we,
	input  logic [sfu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sfu_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import sfu_pkg::*;

	logic [MAXT_W-1:0] max_terms_q;
	logic [THR_W-1:0]  threshold_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_terms_q <= MAXT_W'(10);
			threshold_q <= THR_W'(17);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_TERMS: max_terms_q <= cfg_data[MAXT_W-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sfu_ctrl #(.TERM_LIMIT(TERM_LIMIT)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_command (req.command),
		.max_terms   (max_terms_q),
		.cmd         (cmd),
		.stat        (stat)
	);

	sfu_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_command    (req.command),
		.req_operand    (req.operand),
		.threshold      (threshold_q),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_value      (rsp.value),
		.rsp_status     (rsp.status),
		.rsp_terms_used (rsp.terms_used)
	);
endmodule
